// File: rtl/bqlt_pkg.sv
// Shared types and constants for the brace/quote line tokeniser.
// Used by bqlt_step and brace_quote_line_tokenizer; no dependencies.
package bqlt_pkg;

    localparam int unsigned DEF_MAX_BRACE_DEPTH = 15;
    localparam int unsigned DEF_MAX_WORD_COUNT  = 255;

    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_DQUOTE = 8'h22;
    localparam logic [7:0] BYTE_SQUOTE = 8'h27;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_LBRACE = 8'h7B;
    localparam logic [7:0] BYTE_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        SKIP_NONE      = 2'd0,
        SKIP_CR_OR_LF  = 2'd1,
        SKIP_LF        = 2'd2
    } skip_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OPEN_SQUOTE = 3'd1,
        ST_OPEN_DQUOTE = 3'd2,
        ST_OPEN_BRACE  = 3'd3,
        ST_TRUNCATED   = 3'd4,
        ST_BRACE_ERROR = 3'd5,
        ST_BLANK       = 3'd6
    } status_t;

    typedef struct packed {
        logic  inside_word;
        logic  single_quoted;
        logic  double_quoted;
        logic  escape_pending;
        logic  swallow_lf_after_cr;
        skip_t brace_newline_skip;
        logic  brace_fault;
    } flags_t;

    typedef struct packed {
        logic       emit;
        logic       char_valid;
        logic [7:0] char_value;
        logic       word_end;
        logic       line_end;
        status_t    line_status;
        logic [7:0] word_count;
    } result_t;

endpackage

// File: rtl/bqlt_step.sv
// Per-byte next-state and result logic of the line tokeniser.
// Purely combinational; depends on bqlt_pkg.
module bqlt_step #(
    parameter int unsigned MAX_BRACE_DEPTH = bqlt_pkg::DEF_MAX_BRACE_DEPTH,
    parameter int unsigned MAX_WORD_COUNT  = bqlt_pkg::DEF_MAX_WORD_COUNT,
    localparam int unsigned DW = $clog2(MAX_BRACE_DEPTH + 1),
    localparam int unsigned CW = $clog2(MAX_WORD_COUNT + 1)
) (
    input  logic [7:0]        in_byte,
    input  logic              strip_nl,
    input  bqlt_pkg::flags_t  flags,
    input  logic [DW-1:0]     depth,
    input  logic [CW-1:0]     words,
    output bqlt_pkg::flags_t  flags_next,
    output logic [DW-1:0]     depth_next,
    output logic [CW-1:0]     words_next,
    output bqlt_pkg::result_t res
);

    logic          quoted;
    logic          grouped;
    logic          skip_hit;
    logic [CW-1:0] words_inc;
    logic [CW-1:0] words_cnt;
    logic [16:0]   count_wide;

    assign quoted    = flags.single_quoted || flags.double_quoted;
    assign grouped   = quoted || (depth != '0);
    assign words_inc = (words < CW'(MAX_WORD_COUNT)) ? words + CW'(1) : words;

    always_comb
    begin
        flags_next = flags;
        depth_next = depth;
        words_next = words;
        res        = '0;
        skip_hit   = 1'b0;
        words_cnt  = words;
        flags_next.swallow_lf_after_cr = 1'b0;

        priority if (in_byte == bqlt_pkg::BYTE_NUL)
        begin
            // abort the line: status from the open constructs
            res.emit     = 1'b1;
            res.line_end = 1'b1;
            priority if (flags.brace_fault)   res.line_status = bqlt_pkg::ST_BRACE_ERROR;
            else if (flags.single_quoted)     res.line_status = bqlt_pkg::ST_OPEN_SQUOTE;
            else if (flags.double_quoted)     res.line_status = bqlt_pkg::ST_OPEN_DQUOTE;
            else if (depth != '0)             res.line_status = bqlt_pkg::ST_OPEN_BRACE;
            else                              res.line_status = bqlt_pkg::ST_TRUNCATED;
            flags_next = '0;
            depth_next = '0;
            words_next = '0;
        end
        else if (flags.swallow_lf_after_cr && in_byte == bqlt_pkg::BYTE_LF)
        begin
            // drop the LF of a CR LF pair
        end
        else
        begin
            unique case (flags.brace_newline_skip)
                bqlt_pkg::SKIP_CR_OR_LF:
                begin
                    if (in_byte == bqlt_pkg::BYTE_CR)
                    begin
                        flags_next.brace_newline_skip = bqlt_pkg::SKIP_LF;
                        skip_hit = 1'b1;
                    end
                    else
                    begin
                        flags_next.brace_newline_skip = bqlt_pkg::SKIP_NONE;
                        skip_hit = (in_byte == bqlt_pkg::BYTE_LF);
                    end
                end
                bqlt_pkg::SKIP_LF:
                begin
                    flags_next.brace_newline_skip = bqlt_pkg::SKIP_NONE;
                    skip_hit = (in_byte == bqlt_pkg::BYTE_LF);
                end
                default:
                begin
                    flags_next.brace_newline_skip = bqlt_pkg::SKIP_NONE;
                end
            endcase

            if (!skip_hit)
            begin
                priority if (flags.escape_pending)
                begin
                    flags_next.escape_pending = 1'b0;
                    flags_next.inside_word    = 1'b1;
                    res.emit       = 1'b1;
                    res.char_valid = 1'b1;
                    res.char_value = in_byte;
                end
                else if (in_byte == bqlt_pkg::BYTE_LBRACE)
                begin
                    flags_next.inside_word = 1'b1;
                    if (depth >= DW'(MAX_BRACE_DEPTH))
                    begin
                        flags_next.brace_fault = 1'b1;
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.char_value = in_byte;
                    end
                    else
                    begin
                        depth_next = depth + DW'(1);
                        if (grouped)
                        begin
                            res.emit       = 1'b1;
                            res.char_valid = 1'b1;
                            res.char_value = in_byte;
                        end
                        else if (strip_nl)
                        begin
                            flags_next.brace_newline_skip = bqlt_pkg::SKIP_CR_OR_LF;
                        end
                    end
                end
                else if (in_byte == bqlt_pkg::BYTE_RBRACE)
                begin
                    flags_next.inside_word = 1'b1;
                    if (depth == '0)
                    begin
                        flags_next.brace_fault = 1'b1;
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.char_value = in_byte;
                    end
                    else
                    begin
                        depth_next = depth - DW'(1);
                        // outermost close brace is dropped
                        if (depth != DW'(1) || quoted)
                        begin
                            res.emit       = 1'b1;
                            res.char_valid = 1'b1;
                            res.char_value = in_byte;
                        end
                    end
                end
                else if (in_byte == bqlt_pkg::BYTE_SQUOTE)
                begin
                    flags_next.inside_word = 1'b1;
                    if (flags.double_quoted || depth != '0)
                    begin
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.char_value = in_byte;
                    end
                    else
                    begin
                        flags_next.single_quoted = !flags.single_quoted;
                    end
                end
                else if (in_byte == bqlt_pkg::BYTE_DQUOTE)
                begin
                    flags_next.inside_word = 1'b1;
                    if (flags.single_quoted || depth != '0)
                    begin
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.char_value = in_byte;
                    end
                    else
                    begin
                        flags_next.double_quoted = !flags.double_quoted;
                    end
                end
                else if (in_byte == bqlt_pkg::BYTE_BSLASH)
                begin
                    flags_next.escape_pending = 1'b1;
                    flags_next.inside_word    = 1'b1;
                end
                else if (in_byte <= bqlt_pkg::BYTE_SPACE)
                begin
                    if (grouped)
                    begin
                        flags_next.inside_word = 1'b1;
                        if (in_byte != bqlt_pkg::BYTE_CR)
                        begin
                            res.emit       = 1'b1;
                            res.char_valid = 1'b1;
                            res.char_value = in_byte;
                        end
                    end
                    else
                    begin
                        if (flags.inside_word)
                        begin
                            words_cnt = words_inc;
                        end
                        if (in_byte == bqlt_pkg::BYTE_CR || in_byte == bqlt_pkg::BYTE_LF)
                        begin
                            res.emit     = 1'b1;
                            res.word_end = flags.inside_word;
                            res.line_end = 1'b1;
                            priority if (flags.brace_fault)
                                res.line_status = bqlt_pkg::ST_BRACE_ERROR;
                            else if (words_cnt == '0)
                                res.line_status = bqlt_pkg::ST_BLANK;
                            else
                                res.line_status = bqlt_pkg::ST_OK;
                            flags_next = '0;
                            depth_next = '0;
                            words_next = '0;
                            flags_next.swallow_lf_after_cr = (in_byte == bqlt_pkg::BYTE_CR);
                        end
                        else
                        begin
                            // separator: close an open word, drop the byte
                            flags_next.inside_word = 1'b0;
                            words_next   = words_cnt;
                            res.emit     = flags.inside_word;
                            res.word_end = flags.inside_word;
                        end
                    end
                end
                else
                begin
                    flags_next.inside_word = 1'b1;
                    res.emit       = 1'b1;
                    res.char_valid = 1'b1;
                    res.char_value = in_byte;
                end
            end
        end

        count_wide = 17'(words_cnt);
        if (res.line_end)
        begin
            res.word_count = (count_wide > 17'd255) ? 8'hFF : count_wide[7:0];
        end
    end

endmodule

// File: rtl/brace_quote_line_tokenizer.sv
// A byte's result appears in the output register in the cycle after its transfer.
// Throughput: one byte per cycle while in_stall is low; the single-pass tokeniser step sets this figure.
// A result held by out_stall is kept in the output register while in_stall is raised.
// Reset (rst_n, asynchronous, active low) clears the line state, the output valid flag
// and the brace newline strip setting; the output payload is not reset.
// Top level of the line tokeniser; depends on bqlt_pkg and bqlt_step.
module brace_quote_line_tokenizer #(
    parameter int unsigned MAX_BRACE_DEPTH = bqlt_pkg::DEF_MAX_BRACE_DEPTH,
    parameter int unsigned MAX_WORD_COUNT  = bqlt_pkg::DEF_MAX_WORD_COUNT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] char_value,
    output logic       word_end,
    output logic       line_end,
    output logic [2:0] line_status,
    output logic [7:0] word_count
);

    localparam int unsigned DW = $clog2(MAX_BRACE_DEPTH + 1);
    localparam int unsigned CW = $clog2(MAX_WORD_COUNT + 1);

    logic              strip_reg;
    bqlt_pkg::flags_t  flags_reg;
    bqlt_pkg::flags_t  flags_next;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic [CW-1:0]     words_reg;
    logic [CW-1:0]     words_next;
    bqlt_pkg::result_t res;
    bqlt_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    bqlt_step #(
        .MAX_BRACE_DEPTH (MAX_BRACE_DEPTH),
        .MAX_WORD_COUNT  (MAX_WORD_COUNT)
    ) u_step (
        .in_byte    (in_byte),
        .strip_nl   (strip_reg),
        .flags      (flags_reg),
        .depth      (depth_reg),
        .words      (words_reg),
        .flags_next (flags_next),
        .depth_next (depth_next),
        .words_next (words_next),
        .res        (res)
    );

    always_comb
    begin
        priority if (accept && res.emit) out_valid_next = 1'b1;
        else if (!out_stall)             out_valid_next = 1'b0;
        else                             out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg     <= 1'b0;
            flags_reg     <= '0;
            depth_reg     <= '0;
            words_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                strip_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                flags_reg <= flags_next;
                depth_reg <= depth_next;
                words_reg <= words_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load on a transfer that yields a result
    always_ff @(posedge clk)
    begin
        if (accept && res.emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_valid  = res_reg.char_valid;
    assign char_value  = res_reg.char_value;
    assign word_end    = res_reg.word_end;
    assign line_end    = res_reg.line_end;
    assign line_status = 3'(res_reg.line_status);
    assign word_count  = res_reg.word_count;

    a_nul_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_byte == bqlt_pkg::BYTE_NUL |=> out_valid && line_end && !word_end)
        else $error("NUL byte did not close the line");

    a_char_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> !word_end && !line_end)
        else $error("word byte carried an end mark");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end |-> line_status == 3'd0 && word_count == 8'd0)
        else $error("status or count set without line end");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> line_status != 3'd7)
        else $error("line status out of range");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.line_end |=> words_reg == '0 && depth_reg == '0)
        else $error("line state not cleared at line end");

endmodule
